### rtl/four_level_page_table_mapper_top_macros.svh
// assertion macros for the page table mapper
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_TOP_MACROS_SVH

// same-cycle implication
`define FLPTM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mapper assertion failed");

// next-cycle implication
`define FLPTM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mapper assertion failed");

`endif

### rtl/flptm_pkg.sv
package flptm_pkg;

   localparam int TABLE_PAGES       = 64;
   localparam int INDEX_W           = 9;
   localparam int ENTRIES_PER_TABLE = 1 << INDEX_W;
   localparam int PAGE_W            = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int NF_W              = $clog2(TABLE_PAGES + 1);
   localparam int ADDR_W            = PAGE_W + INDEX_W;
   localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int LEVEL_W           = 2;
   localparam int OFFSET_W          = 12;
   localparam int VA_W              = 48;
   localparam int PA_W              = 52;
   localparam int ENTRY_W           = 64;

   localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;
   localparam logic [2:0]         LINK_FLAGS = 3'b111;

   localparam logic CMD_MAP    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_EVAL  = 6'b001000,
      S_ALLOC = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

endpackage

### rtl/four_level_page_table_mapper_top.sv
// one request at a time; a walk reads one table entry per level from one store port
// each level steps S_READ then S_EVAL, each table allocated adds S_ALLOC, and S_DONE hands
// the result to the response register; a walk can fail at level 0 to 2, never at the last level
// no new request is taken until the result is registered and the state is back in S_IDLE
// reset (synchronous): the store is then cleared one entry a cycle, all TABLE_PAGES * 512
// entries (32768 at 64 pages), with req_ready low; csr writes are taken throughout
module four_level_page_table_mapper_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [flptm_pkg::PA_W-1:0]       csr_table_pool_base,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [flptm_pkg::VA_W-1:0]       req_virtual_address,
   input  logic [flptm_pkg::PA_W-1:0]       req_physical_address,
   input  logic [flptm_pkg::OFFSET_W-1:0]   req_page_flags,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic [flptm_pkg::ENTRY_W-1:0]    rsp_entry_value
);

`include "four_level_page_table_mapper_top_macros.svh"

   // entry store: bit 64 marks a write made after its page was allocated
   logic [flptm_pkg::ENTRY_W:0]       store_mem [flptm_pkg::STORE_DEPTH];
   logic [flptm_pkg::ENTRY_W:0]       rd_data_ff;

   flptm_pkg::state_type              state_ff, state_in;
   logic [flptm_pkg::ADDR_W-1:0]      clear_cnt_ff, clear_cnt_in;
   logic [flptm_pkg::NF_W-1:0]        next_free_ff, next_free_in;
   logic [flptm_pkg::PA_W-1:0]        base_ff, base_in;
   logic [flptm_pkg::PAGE_W-1:0]      page_ff, page_in;
   logic [flptm_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic                              cmd_ff, cmd_in;
   logic [flptm_pkg::VA_W-1:0]        va_ff, va_in;
   logic [flptm_pkg::PA_W-1:0]        pa_ff, pa_in;
   logic [flptm_pkg::OFFSET_W-1:0]    flags_ff, flags_in;
   logic                              res_ok_ff, res_ok_in;
   logic [flptm_pkg::ENTRY_W-1:0]     res_val_ff, res_val_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic [flptm_pkg::ENTRY_W-1:0]     rsp_val_ff, rsp_val_in;

   logic [flptm_pkg::INDEX_W-1:0]     index;
   logic [flptm_pkg::ADDR_W-1:0]      slot;
   logic                              mem_we;
   logic [flptm_pkg::ADDR_W-1:0]      mem_waddr;
   logic [flptm_pkg::ENTRY_W:0]       mem_wdata;
   logic [flptm_pkg::ENTRY_W-1:0]     base_aligned;
   logic [flptm_pkg::ENTRY_W-1:0]     entry;
   logic                              page_alloc;
   logic [flptm_pkg::ENTRY_W:0]       diff;
   logic                              in_pool;
   logic [flptm_pkg::ENTRY_W-1:0]     link_value;
   logic [flptm_pkg::NF_W-1:0]        next_free_inc;
   logic                              rsp_free;
   logic                              req_xact;

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == flptm_pkg::S_IDLE);
   assign req_xact        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_entry_value = rsp_val_ff;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (level_ff)
         2'd0:    index = va_ff[47:39];
         2'd1:    index = va_ff[38:30];
         2'd2:    index = va_ff[29:21];
         default: index = va_ff[20:12];
      endcase
   end

   assign slot          = {page_ff, index};
   assign base_aligned  = {12'd0, base_ff[flptm_pkg::PA_W-1:flptm_pkg::OFFSET_W], 12'd0};
   assign page_alloc    = flptm_pkg::NF_W'(page_ff) < next_free_ff;
   assign entry         = (page_alloc && !rd_data_ff[flptm_pkg::ENTRY_W]) ?
                          '0 : rd_data_ff[flptm_pkg::ENTRY_W-1:0];
   assign diff          = {1'b0, entry[63:12], 12'd0} - {1'b0, base_aligned};
   assign in_pool       = !diff[flptm_pkg::ENTRY_W] &&
                          (diff[63:12] < 52'(flptm_pkg::TABLE_PAGES));
   assign next_free_inc = next_free_ff + flptm_pkg::NF_W'(1);
   assign link_value    = (base_aligned + (64'(next_free_ff) << 12)) |
                          {61'd0, flptm_pkg::LINK_FLAGS};

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      next_free_in = next_free_ff;
      base_in      = base_ff;
      page_in      = page_ff;
      level_in     = level_ff;
      cmd_in       = cmd_ff;
      va_in        = va_ff;
      pa_in        = pa_ff;
      flags_in     = flags_ff;
      res_ok_in    = res_ok_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_val_in   = rsp_val_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot;
      mem_wdata    = '0;

      if (csr_valid && csr_ready) begin
         base_in = csr_table_pool_base;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         flptm_pkg::S_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_cnt_ff;
            clear_cnt_in = clear_cnt_ff + flptm_pkg::ADDR_W'(1);
            if (clear_cnt_ff == flptm_pkg::ADDR_W'(flptm_pkg::STORE_DEPTH - 1)) begin
               state_in = flptm_pkg::S_IDLE;
            end
         end
         flptm_pkg::S_IDLE: begin
            if (req_xact) begin
               cmd_in   = req_command;
               va_in    = req_virtual_address;
               pa_in    = req_physical_address;
               flags_in = req_page_flags;
               page_in  = '0;
               level_in = '0;
               state_in = flptm_pkg::S_READ;
            end
         end
         flptm_pkg::S_READ: begin
            state_in = flptm_pkg::S_EVAL;
         end
         flptm_pkg::S_EVAL: begin
            state_in   = flptm_pkg::S_DONE;
            res_ok_in  = 1'b0;
            res_val_in = '0;
            if (level_ff == flptm_pkg::LAST_LEVEL) begin
               res_ok_in = 1'b1;
               if (cmd_ff == flptm_pkg::CMD_MAP) begin
                  res_val_in = {12'd0, pa_ff | {40'd0, flags_ff}};
                  mem_we     = 1'b1;
                  mem_wdata  = {page_alloc, 12'd0, pa_ff | {40'd0, flags_ff}};
               end else begin
                  res_val_in = entry;
               end
            end else if (entry[0]) begin
               if (in_pool) begin
                  page_in  = diff[flptm_pkg::OFFSET_W +: flptm_pkg::PAGE_W];
                  level_in = level_ff + 2'd1;
                  state_in = flptm_pkg::S_READ;
               end
            end else if (cmd_ff == flptm_pkg::CMD_MAP &&
                         next_free_ff < flptm_pkg::NF_W'(flptm_pkg::TABLE_PAGES)) begin
               state_in = flptm_pkg::S_ALLOC;
            end
         end
         flptm_pkg::S_ALLOC: begin
            // fresh page counts as allocated before the link is written
            mem_we       = 1'b1;
            mem_wdata    = {flptm_pkg::NF_W'(page_ff) < next_free_inc, link_value};
            next_free_in = next_free_inc;
            page_in      = next_free_ff[flptm_pkg::PAGE_W-1:0];
            level_in     = level_ff + 2'd1;
            state_in     = flptm_pkg::S_READ;
         end
         flptm_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_val_in   = res_val_ff;
               state_in     = flptm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = flptm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flptm_pkg::S_CLEAR;
         clear_cnt_ff <= '0;
         next_free_ff <= flptm_pkg::NF_W'(1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         next_free_ff <= next_free_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      level_ff   <= level_in;
      cmd_ff     <= cmd_in;
      va_ff      <= va_in;
      pa_ff      <= pa_in;
      flags_ff   <= flags_in;
      res_ok_ff  <= res_ok_in;
      res_val_ff <= res_val_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_val_ff <= rsp_val_in;
   end

   `FLPTM_ASSERT_IMP(a_pool_bound, 1'b1, next_free_ff <= flptm_pkg::NF_W'(flptm_pkg::TABLE_PAGES))
   `FLPTM_ASSERT_NXT(a_alloc_bump, state_ff == flptm_pkg::S_ALLOC, next_free_ff == $past(next_free_inc))
   `FLPTM_ASSERT_IMP(a_fail_zero, rsp_valid_ff && !rsp_ok_ff, rsp_val_ff == '0)
   `FLPTM_ASSERT_NXT(a_req_starts_walk, req_xact, state_ff == flptm_pkg::S_READ && level_ff == 2'd0)

endmodule

### tb/tb_four_level_page_table_mapper_top.sv
`timescale 1ns / 100ps

module tb_four_level_page_table_mapper_top;

   typedef struct {
      logic                           command;
      logic [flptm_pkg::VA_W-1:0]     va;
      logic [flptm_pkg::PA_W-1:0]     pa;
      logic [flptm_pkg::OFFSET_W-1:0] flags;
      logic                           ok;
      logic [flptm_pkg::ENTRY_W-1:0]  entry;
   } mapping_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [flptm_pkg::PA_W-1:0]     csr_table_pool_base = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_command = flptm_pkg::CMD_MAP;
   logic [flptm_pkg::VA_W-1:0]     req_virtual_address = '0;
   logic [flptm_pkg::PA_W-1:0]     req_physical_address = '0;
   logic [flptm_pkg::OFFSET_W-1:0] req_page_flags = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_ok;
   logic [flptm_pkg::ENTRY_W-1:0]  rsp_entry_value;

   // shadow of the table pool
   bit [flptm_pkg::ENTRY_W-1:0] page_store [flptm_pkg::STORE_DEPTH];
   int                          next_free_page = 1;
   logic [flptm_pkg::PA_W-1:0]  pool_base = '0;

   mapping_type                pending_walks [$];
   mapping_type                awaited_leaves [$];
   logic [flptm_pkg::VA_W-1:0] mapped_vas [$];
   mapping_type                in_flight;
   bit                         req_taken = 1'b0;
   int                         walks_open = 0;
   int                         failures = 0;
   int                         send_idle_pct = 0;
   int                         stall_pct = 0;

   four_level_page_table_mapper_top DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_table_pool_base  (csr_table_pool_base),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_virtual_address  (req_virtual_address),
      .req_physical_address (req_physical_address),
      .req_page_flags       (req_page_flags),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ok               (rsp_ok),
      .rsp_entry_value      (rsp_entry_value)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic bit descend_level(input int page,
                                        input logic [flptm_pkg::INDEX_W-1:0] idx,
                                        input bit alloc, output int next_page);
      int       slot;
      bit [63:0] link;
      bit [63:0] link_addr;
      bit [63:0] base_al;
      slot = page * flptm_pkg::ENTRIES_PER_TABLE + idx;
      link = page_store[slot];
      base_al = {12'd0, pool_base} & ~64'hFFF;
      next_page = 0;
      if (link[0]) begin
         link_addr = link & ~64'hFFF;
         if (link_addr < base_al ||
             ((link_addr - base_al) >> 12) >= flptm_pkg::TABLE_PAGES)
            return 1'b0;
         next_page = int'((link_addr - base_al) >> 12);
         return 1'b1;
      end
      if (!alloc || next_free_page >= flptm_pkg::TABLE_PAGES)
         return 1'b0;
      next_page = next_free_page;
      next_free_page++;
      for (int k = 0; k < flptm_pkg::ENTRIES_PER_TABLE; k++)
         page_store[next_page * flptm_pkg::ENTRIES_PER_TABLE + k] = '0;
      page_store[slot] = (base_al + (64'(next_page) << 12)) | 64'(flptm_pkg::LINK_FLAGS);
      return 1'b1;
   endfunction

   function automatic void predict_walk(inout mapping_type m);
      int p3;
      int p2;
      int p1;
      int slot;
      bit alloc;
      alloc = (m.command == flptm_pkg::CMD_MAP);
      m.ok = 1'b0;
      m.entry = '0;
      if (!descend_level(0, m.va[47:39], alloc, p3)) return;
      if (!descend_level(p3, m.va[38:30], alloc, p2)) return;
      if (!descend_level(p2, m.va[29:21], alloc, p1)) return;
      slot = p1 * flptm_pkg::ENTRIES_PER_TABLE + m.va[20:12];
      if (alloc)
         page_store[slot] = {12'd0, m.pa} | {52'd0, m.flags};
      m.ok = 1'b1;
      m.entry = page_store[slot];
   endfunction

   function automatic logic [flptm_pkg::VA_W-1:0] rand_va();
      return flptm_pkg::VA_W'({$urandom, $urandom});
   endfunction

   function automatic logic [flptm_pkg::PA_W-1:0] rand_pa();
      return flptm_pkg::PA_W'({$urandom, $urandom});
   endfunction

   task automatic queue_walk(input logic cmd, input logic [flptm_pkg::VA_W-1:0] va,
                             input logic [flptm_pkg::PA_W-1:0] pa,
                             input logic [flptm_pkg::OFFSET_W-1:0] flags);
      mapping_type m;
      m.command = cmd;
      m.va = va;
      m.pa = pa;
      m.flags = flags;
      predict_walk(m);
      if (m.ok && cmd == flptm_pkg::CMD_MAP)
         mapped_vas.push_back(va);
      pending_walks.push_back(m);
      walks_open++;
   endtask

   // mostly walks along already mapped prefixes, the rest fresh addresses
   task automatic random_walk();
      int                         pick;
      logic [flptm_pkg::VA_W-1:0] known;
      logic [flptm_pkg::VA_W-1:0] va;
      logic                       cmd;
      pick = $urandom_range(99);
      va = rand_va();
      known = (mapped_vas.size() != 0) ?
              mapped_vas[$urandom_range(mapped_vas.size() - 1)] : rand_va();
      if (pick < 45) begin
         cmd = flptm_pkg::CMD_MAP;
         va = {known[47:21], va[20:0]};
      end else if (pick < 60) begin
         cmd = flptm_pkg::CMD_LOOKUP;
         va = known;
      end else if (pick < 75) begin
         cmd = flptm_pkg::CMD_LOOKUP;
         va = {known[47:21], va[20:0]};
      end else if (pick < 80) begin
         cmd = flptm_pkg::CMD_MAP;
         va = {known[47:30], va[29:0]};
      end else if (pick < 92) begin
         cmd = flptm_pkg::CMD_MAP;
      end else begin
         cmd = flptm_pkg::CMD_LOOKUP;
      end
      queue_walk(cmd, va, rand_pa(), flptm_pkg::OFFSET_W'($urandom_range(4095)));
   endtask

   task automatic write_pool_base(input logic [flptm_pkg::PA_W-1:0] base);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_table_pool_base <= base;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool_base = base;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_walks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            in_flight = pending_walks.pop_front();
            req_valid <= 1'b1;
            req_command <= in_flight.command;
            req_virtual_address <= in_flight.va;
            req_physical_address <= in_flight.pa;
            req_page_flags <= in_flight.flags;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      mapping_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            awaited_leaves.push_back(in_flight);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_leaves.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual ok %0b entry %h",
                        $time, rsp_ok, rsp_entry_value);
               failures++;
            end else begin
               want = awaited_leaves.pop_front();
               walks_open--;
               if (rsp_ok !== want.ok) begin
                  $display("%0t: va %h ok mismatch, expected %0b, actual %0b",
                           $time, want.va, want.ok, rsp_ok);
                  failures++;
               end
               if (rsp_entry_value !== want.entry) begin
                  $display("%0t: va %h entry_value mismatch, expected %h, actual %h",
                           $time, want.va, want.entry, rsp_entry_value);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      logic [flptm_pkg::PA_W-1:0] bases [8];
      bases[0] = '0;
      bases[1] = '0;
      bases[2] = '1;
      bases[3] = '0;
      bases[4] = 52'h3ABC;
      bases[5] = '0;
      bases[6] = rand_pa();
      bases[7] = '0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // low bits of the base are ignored
      write_pool_base(52'hFFF);
      @(posedge clock);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'h0, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_MAP,    48'h0, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'h0, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_MAP,    48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'hFFFF_FFFF_EFFF, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_MAP,    48'hFFFF_FFFF_F123, 52'h1_2345_6789_A000, 12'h5A5);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
      queue_walk(flptm_pkg::CMD_MAP,    48'hAAAA_AAAA_AAAA, 52'h5_5555_5555_5555, 12'hAAA);
      queue_walk(flptm_pkg::CMD_MAP,    48'h5555_5555_5555, 52'hA_AAAA_AAAA_AAAA, 12'h555);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'hAAAA_AAAA_AAAA, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'h5555_5555_5555, 52'h0, 12'h000);
      // missing third, second and top level
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'h0000_4000_0000, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_MAP,    48'h0000_4000_0000, 52'h0000_0000_1000, 12'h001);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'h0000_0020_0000, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_LOOKUP, 48'h8000_0000_0000, 52'h0, 12'h000);
      queue_walk(flptm_pkg::CMD_MAP,    48'h0000_0000_1000, 52'h0_0000_0ABC_D000, 12'h800);

      for (int ph = 1; ph <= 8; ph++) begin
         while (walks_open != 0) @(negedge clock);
         write_pool_base(bases[ph - 1]);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 82;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 82;
            end
            default: begin
               send_idle_pct = 33;
               stall_pct = 33;
            end
         endcase
         @(posedge clock);
         repeat (85) random_walk();
      end

      while (walks_open != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("tb_four_level_page_table_mapper_top passed");
      end else begin
         $display("tb_four_level_page_table_mapper_top failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_four_level_page_table_mapper_top failed");
      $finish;
   end

endmodule
